/* rtl/bsde_pkg.sv */
// Package for the B-spline de Boor evaluator: sizes, codes, command and status types.
// No dependencies.
package bsde_pkg;
	localparam int MaxPoints = 64;
	localparam int MaxOrder = 7;
	localparam int FracBits = 16;
	localparam int KnotDepth = MaxPoints + MaxOrder + 1;
	localparam int PtW = $clog2(MaxPoints);
	localparam int KnW = $clog2(KnotDepth);
	localparam int OrdW = $clog2(MaxOrder + 1);
	localparam int SlotW = 7;
	localparam int CntW = 7;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_KNOT = 2'd1;
	localparam logic [1:0] KIND_EVAL = 2'd2;

	localparam logic CFG_ORDER = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_KNOT = 3'd1,
		OP_POINT = 3'd2,
		OP_DIV = 3'd3,
		OP_BLEND = 3'd4
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [KnW-1:0] addr;
		logic [OrdW-1:0] lane;
		logic [1:0] sel;
		logic [OrdW-1:0] dst;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic blend_done;
		logic signed [31:0] rd;
	} dp_sts_t;
endpackage

/* rtl/bsde_datapath.sv */
// Datapath: point and knot memories, work registers, restoring divider, blend multiplier.
// Depends on bsde_pkg.
module bsde_datapath (
	input logic clk,
	input logic arst_n,
	input logic pt_we,
	input logic [bsde_pkg::PtW-1:0] pt_wa,
	input logic signed [31:0] wx,
	input logic signed [31:0] wy,
	input logic signed [31:0] wz,
	input logic kn_we,
	input logic [bsde_pkg::KnW-1:0] kn_wa,
	input logic signed [31:0] wk,
	input bsde_pkg::dp_cmd_t cmd,
	input logic signed [32:0] num,
	input logic signed [32:0] den,
	output bsde_pkg::dp_sts_t sts,
	output logic signed [31:0] px,
	output logic signed [31:0] py,
	output logic signed [31:0] pz
);
	logic signed [31:0] mx[bsde_pkg::MaxPoints];
	logic signed [31:0] my[bsde_pkg::MaxPoints];
	logic signed [31:0] mz[bsde_pkg::MaxPoints];
	logic signed [31:0] mk[bsde_pkg::KnotDepth];
	logic signed [31:0] rk_q, rx_q, ry_q, rz_q;
	logic signed [31:0] dx_q[bsde_pkg::MaxOrder+1];
	logic signed [31:0] dy_q[bsde_pkg::MaxOrder+1];
	logic signed [31:0] dz_q[bsde_pkg::MaxOrder+1];
	logic [32:0] rem_q, dv_q;
	logic [16:0] quo_q;
	logic [4:0] dcnt_q;
	logic div_busy_q, div_done_q;
	logic [16:0] alpha_q;
	logic [1:0] bph_q;
	logic bl_done_q;
	logic signed [31:0] ba_q, bb_q;
	logic signed [50:0] pa_s1, pb_s1;
	logic [33:0] trial;

	always_ff @(posedge clk) begin
		if (pt_we) begin
			mx[pt_wa] <= wx;
			my[pt_wa] <= wy;
			mz[pt_wa] <= wz;
		end
		if (kn_we) mk[kn_wa] <= wk;
		rk_q <= mk[cmd.addr];
		rx_q <= mx[cmd.addr[bsde_pkg::PtW-1:0]];
		ry_q <= my[cmd.addr[bsde_pkg::PtW-1:0]];
		rz_q <= mz[cmd.addr[bsde_pkg::PtW-1:0]];
	end

	// point load: sel[0] zero-fills the lane (index outside the curve)
	always_ff @(posedge clk) begin
		if (cmd.op == bsde_pkg::OP_POINT) begin
			dx_q[cmd.lane] <= cmd.sel[0] ? 32'sd0 : rx_q;
			dy_q[cmd.lane] <= cmd.sel[0] ? 32'sd0 : ry_q;
			dz_q[cmd.lane] <= cmd.sel[0] ? 32'sd0 : rz_q;
		end else if (bph_q == 2'd3) begin
			priority case (cmd.sel)
				2'd0: dx_q[cmd.dst] <= 32'(pa_s1 + pb_s1 + 51'sd32768 >>> 16);
				2'd1: dy_q[cmd.dst] <= 32'(pa_s1 + pb_s1 + 51'sd32768 >>> 16);
				default: dz_q[cmd.dst] <= 32'(pa_s1 + pb_s1 + 51'sd32768 >>> 16);
			endcase
		end
	end

	// alpha = clamp(floor(num<<16 / den)); restoring, one quotient bit a cycle
	assign trial = {rem_q, 1'b0} - {1'b0, dv_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			dcnt_q <= '0;
			alpha_q <= '0;
			rem_q <= '0;
			dv_q <= '0;
			quo_q <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.op == bsde_pkg::OP_DIV && !div_busy_q && !div_done_q) begin
				if (den == 0 || (den > 0 ? num <= 0 : num >= 0)) begin
					alpha_q <= '0;
					div_done_q <= 1'b1;
				end else if (den > 0 ? num >= den : num <= den) begin
					alpha_q <= 17'h10000;
					div_done_q <= 1'b1;
				end else begin
					rem_q <= den > 0 ? 33'(num) : 33'(-num);
					dv_q <= den > 0 ? 33'(den) : 33'(-den);
					quo_q <= '0;
					dcnt_q <= 5'd16;
					div_busy_q <= 1'b1;
				end
			end else if (div_busy_q) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], 1'b0};
					quo_q <= {quo_q[15:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd1) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
					alpha_q <= trial[33] ? {quo_q[15:0], 1'b0} : {quo_q[15:0], 1'b1};
				end
			end
		end
	end

	// blend: phase 1 fetch, 2 multiply, 3 write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bph_q <= '0;
			bl_done_q <= 1'b0;
		end else begin
			bl_done_q <= 1'b0;
			if (cmd.op == bsde_pkg::OP_BLEND && bph_q == 2'd0 && !bl_done_q) bph_q <= 2'd1;
			else if (bph_q == 2'd1) bph_q <= 2'd2;
			else if (bph_q == 2'd2) bph_q <= 2'd3;
			else if (bph_q == 2'd3) begin
				bph_q <= 2'd0;
				bl_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bph_q == 2'd1) begin
			priority case (cmd.sel)
				2'd0: begin ba_q <= dx_q[cmd.dst - 1'b1]; bb_q <= dx_q[cmd.dst]; end
				2'd1: begin ba_q <= dy_q[cmd.dst - 1'b1]; bb_q <= dy_q[cmd.dst]; end
				default: begin ba_q <= dz_q[cmd.dst - 1'b1]; bb_q <= dz_q[cmd.dst]; end
			endcase
		end
		pa_s1 <= 51'($signed({1'b0, 17'h10000 - alpha_q}) * ba_q);
		pb_s1 <= 51'($signed({1'b0, alpha_q}) * bb_q);
	end

	assign sts.div_done = div_done_q;
	assign sts.blend_done = bl_done_q;
	assign sts.rd = rk_q;
	assign px = dx_q[cmd.lane];
	assign py = dy_q[cmd.lane];
	assign pz = dz_q[cmd.lane];
endmodule

/* rtl/bsde_ctrl.sv */
// Controller: clamp, span search and the de Boor sequencing over the datapath.
// Depends on bsde_pkg.
module bsde_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] t_in,
	input logic [bsde_pkg::OrdW-1:0] p,
	input logic [bsde_pkg::CntW-1:0] n,
	input bsde_pkg::dp_sts_t sts,
	output bsde_pkg::dp_cmd_t cmd,
	output logic signed [32:0] num,
	output logic signed [32:0] den,
	output logic busy,
	output logic done,
	output logic zero
);
	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_LO = 11'b00000000010,
		S_HI = 11'b00000000100,
		S_SRCH = 11'b00000001000,
		S_LOAD = 11'b00000010000,
		S_KL = 11'b00000100000,
		S_KH = 11'b00001000000,
		S_DIV = 11'b00010000000,
		S_BL = 11'b00100000000,
		S_OUT = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} st_t;
	st_t st_q;
	logic signed [31:0] t_q, kl_q, kh_q;
	logic [7:0] k_q, j_q, kc;
	logic [3:0] r_q, i_q;
	logic [1:0] c_q, w_q;
	logic [7:0] ra;
	logic sx;
	logic [bsde_pkg::OrdW-1:0] lane;
	logic signed [31:0] kv;

	assign kc = 8'(n) + 8'(p) + 8'd1;
	assign kv = (j_q >= kc || j_q >= 8'(bsde_pkg::KnotDepth)) ? 32'sd0 : sts.rd;
	assign busy = st_q != S_IDLE;

	always_comb begin
		ra = j_q;
		sx = 1'b0;
		lane = bsde_pkg::OrdW'(i_q);
		unique case (st_q)
			S_LOAD: begin
				ra = k_q - 8'(p) + 8'(i_q);
				sx = ra >= 8'(n);
			end
			default: ;
		endcase
		cmd.addr = bsde_pkg::KnW'(ra);
		cmd.lane = st_q == S_OUT ? bsde_pkg::OrdW'(p) : lane;
		cmd.dst = bsde_pkg::OrdW'(i_q);
		cmd.sel = st_q == S_LOAD ? {1'b0, sx} : c_q;
		cmd.op = bsde_pkg::OP_NONE;
		unique case (st_q)
			S_LOAD: if (w_q != 0) cmd.op = bsde_pkg::OP_POINT;
			S_DIV: cmd.op = bsde_pkg::OP_DIV;
			S_BL: cmd.op = bsde_pkg::OP_BLEND;
			default: ;
		endcase
	end
	assign num = 33'(t_q) - 33'(kl_q);
	assign den = 33'(kh_q) - 33'(kl_q);

	// every read waits on the counter w_q so that the registered memory data is valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			zero <= 1'b0;
			w_q <= '0;
			t_q <= '0;
			kl_q <= '0;
			kh_q <= '0;
			k_q <= '0;
			j_q <= '0;
			r_q <= '0;
			i_q <= '0;
			c_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					t_q <= t_in;
					w_q <= '0;
					if (n == 0) begin
						zero <= 1'b1;
						done <= 1'b1;
					end else begin
						zero <= 1'b0;
						j_q <= 8'(p);
						st_q <= S_LO;
					end
				end
				S_LO: begin
					w_q <= w_q + 2'd1;
					if (w_q == 2'd2) begin
						w_q <= '0;
						if (t_q < kv) t_q <= kv;
						j_q <= 8'(n);
						st_q <= S_HI;
					end
				end
				S_HI: begin
					w_q <= w_q + 2'd1;
					if (w_q == 2'd2) begin
						w_q <= '0;
						if (t_q > kv) t_q <= kv;
						k_q <= 8'(p);
						j_q <= 8'(p) + 8'd1;
						st_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (j_q >= kc) begin
						i_q <= '0;
						st_q <= S_LOAD;
					end else begin
						w_q <= w_q + 2'd1;
						if (w_q == 2'd2) begin
							w_q <= '0;
							if (kv < t_q) begin
								k_q <= j_q;
								j_q <= j_q + 8'd1;
							end else begin
								i_q <= '0;
								st_q <= S_LOAD;
							end
						end
					end
				end
				S_LOAD: begin
					w_q <= w_q + 2'd1;
					if (w_q == 2'd2) begin
						w_q <= '0;
						if (i_q == 4'(p)) begin
							r_q <= 4'd1;
							i_q <= 4'(p);
							st_q <= p == 0 ? S_WAIT : S_KL;
						end else i_q <= i_q + 4'd1;
					end
				end
				S_KL: begin
					if (w_q == 2'd0) j_q <= 8'(i_q) + k_q - 8'(p);
					w_q <= w_q + 2'd1;
					if (w_q == 2'd3) begin
						w_q <= '0;
						kl_q <= kv;
						j_q <= 8'(i_q) + 8'd1 + k_q - 8'(r_q);
						st_q <= S_KH;
					end
				end
				S_KH: begin
					w_q <= w_q + 2'd1;
					if (w_q == 2'd2) begin
						w_q <= '0;
						kh_q <= kv;
						st_q <= S_DIV;
					end
				end
				S_DIV: if (sts.div_done) begin
					c_q <= '0;
					st_q <= S_BL;
				end
				S_BL: if (sts.blend_done) begin
					if (c_q != 2'd2) c_q <= c_q + 2'd1;
					else if (i_q != r_q) begin
						i_q <= i_q - 4'd1;
						st_q <= S_KL;
					end else if (r_q != 4'(p)) begin
						r_q <= r_q + 4'd1;
						i_q <= 4'(p);
						st_q <= S_KL;
					end else st_q <= S_WAIT;
				end
				S_WAIT: st_q <= S_OUT;
				S_OUT: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/bspline_deboor_evaluator.sv */
// Top level of the B-spline de Boor evaluator; joins controller and datapath.
// Depends on bsde_pkg, bsde_ctrl, bsde_datapath.
//
// Point (kind 0) and knot (kind 1) requests with an in-range slot are stored on
// acceptance. An evaluate request (kind 2) clamps the time to [knot[order],
// knot[point_count]], walks the knots upward from index order to find the span,
// loads order+1 control points, then runs the de Boor triangle: each of the
// order*(order+1)/2 steps reads two knots, runs the shared restoring divider for
// alpha and blends x, y, z on one multiplier pair. One request is worked on at a
// time; a finished point waits in the output register while the next request may
// already be accepted, but an evaluate request is held while that point is
// stalled. No result comes with zero control points other than all-zero output.
module bspline_deboor_evaluator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [6:0] slot,
	input logic signed [31:0] coord_x,
	input logic signed [31:0] coord_y,
	input logic signed [31:0] coord_z,
	input logic signed [31:0] time_value,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [6:0] cfg_data
);
	logic [2:0] order_q;
	logic [6:0] count_q;
	logic acc, busy, done, zero;
	bsde_pkg::dp_cmd_t cmd;
	bsde_pkg::dp_sts_t sts;
	logic signed [32:0] num, den;
	logic signed [31:0] px, py, pz;
	logic [bsde_pkg::CntW-1:0] n_eff;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 3'd3;
			count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsde_pkg::CFG_ORDER: order_q <= cfg_data[2:0];
				bsde_pkg::CFG_COUNT: count_q <= cfg_data;
			endcase
		end
	end
	assign n_eff = count_q > 7'(bsde_pkg::MaxPoints) ? 7'(bsde_pkg::MaxPoints) : count_q;

	// hold off while evaluating, or while a result waits and another could land
	assign in_stall = busy || done || (out_valid && out_stall && kind == bsde_pkg::KIND_EVAL);
	assign acc = in_valid && !in_stall;

	bsde_ctrl u_ctrl (
		.clk, .arst_n,
		.start(acc && kind == bsde_pkg::KIND_EVAL),
		.t_in(time_value), .p(order_q), .n(n_eff), .sts,
		.cmd, .num, .den, .busy, .done, .zero
	);

	bsde_datapath u_dp (
		.clk, .arst_n,
		.pt_we(acc && kind == bsde_pkg::KIND_POINT && slot < 7'(bsde_pkg::MaxPoints)),
		.pt_wa(slot[bsde_pkg::PtW-1:0]),
		.wx(coord_x), .wy(coord_y), .wz(coord_z),
		.kn_we(acc && kind == bsde_pkg::KIND_KNOT && slot < 7'(bsde_pkg::KnotDepth)),
		.kn_wa(slot), .wk(time_value),
		.cmd, .num, .den, .sts, .px, .py, .pz
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (done) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) begin
			pos_x <= zero ? 32'sd0 : px;
			pos_y <= zero ? 32'sd0 : py;
			pos_z <= zero ? 32'sd0 : pz;
		end
	end
endmodule

/* verif/bspline_deboor_evaluator_test.sv */
// Self-checking testbench for bspline_deboor_evaluator: loads points and knots, evaluates curves.
// Depends on bsde_pkg and the evaluator RTL; carries its own fixed-point de Boor predictor.
module bspline_deboor_evaluator_test;
	// kind 3 is not a defined request; the block must drop it
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int ONE_Q = 1 << bsde_pkg::FracBits;
	// settle time before a register write
	localparam int SETTLE_CYCLES = 1500;
	localparam int RAND_PER_PHASE = 100;

	typedef struct {
		logic [1:0] kind;
		logic [6:0] slot;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [31:0] tv;
	} request_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [6:0] slot = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic signed [31:0] coord_z = '0;
	logic signed [31:0] time_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;

	bspline_deboor_evaluator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.slot(slot),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.time_value(time_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's state, updated as requests are accepted
	logic [2:0] spline_order = 3'd3;
	logic [6:0] spline_count = 7'd0;
	logic signed [31:0] ctrl_x [bsde_pkg::MaxPoints];
	logic signed [31:0] ctrl_y [bsde_pkg::MaxPoints];
	logic signed [31:0] ctrl_z [bsde_pkg::MaxPoints];
	logic signed [31:0] knots [bsde_pkg::KnotDepth];

	request_t pending_reqs[$];
	point_t curve_points_due[$];
	request_t cur_req;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	// append a request to the pending queue
	function automatic void queue_req(request_t rq);
		pending_reqs.insert(pending_reqs.size(), rq);
	endfunction

	// knot read as the block sees it: outside the curve's knot range reads zero
	function automatic longint knot_val(int j, int kc);
		if (j >= kc || j >= bsde_pkg::KnotDepth)
			return 0;
		return knots[j];
	endfunction

	// blend weight in Q1.16, saturated to [0, 1]; zero-width span gives zero
	function automatic longint blend_weight(longint num, longint den);
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0)
			return 0;
		if (num >= den)
			return ONE_Q;
		return (num << bsde_pkg::FracBits) / den;
	endfunction

	// de Boor evaluation at time tin with the current shadow state
	function automatic point_t curve_at(logic signed [31:0] tin);
		int p, n, kc, k, idx;
		longint t, lo, hi, kl, kh, a, s;
		longint d [3][bsde_pkg::MaxOrder + 1];
		point_t res;
		res.x = '0;
		res.y = '0;
		res.z = '0;
		p = spline_order;
		n = (spline_count > bsde_pkg::MaxPoints) ? bsde_pkg::MaxPoints : spline_count;
		if (n == 0)
			return res;
		kc = n + p + 1;
		t = tin;
		lo = knot_val(p, kc);
		hi = knot_val(n, kc);
		if (t < lo)
			t = lo;
		if (t > hi)
			t = hi;
		k = p;
		while (k + 1 < kc && knot_val(k + 1, kc) < t)
			k++;
		for (int i = 0; i <= p; i++) begin
			idx = k - p + i;
			if (idx < n) begin
				d[0][i] = ctrl_x[idx];
				d[1][i] = ctrl_y[idx];
				d[2][i] = ctrl_z[idx];
			end else begin
				d[0][i] = 0;
				d[1][i] = 0;
				d[2][i] = 0;
			end
		end
		for (int r = 1; r <= p; r++) begin
			for (int i = p; i >= r; i--) begin
				kl = knot_val(i + k - p, kc);
				kh = knot_val(i + 1 + k - r, kc);
				a = blend_weight(t - kl, kh - kl);
				for (int c = 0; c < 3; c++) begin
					s = (ONE_Q - a) * d[c][i - 1] + a * d[c][i] + (ONE_Q >> 1);
					d[c][i] = s >>> bsde_pkg::FracBits;
				end
			end
		end
		res.x = d[0][p][31:0];
		res.y = d[1][p][31:0];
		res.z = d[2][p][31:0];
		return res;
	endfunction

	// apply one accepted request to the shadow state; evaluations queue a point
	task automatic apply_request(request_t rq);
		case (rq.kind)
			bsde_pkg::KIND_POINT: begin
				if (rq.slot < bsde_pkg::MaxPoints) begin
					ctrl_x[rq.slot] = rq.cx;
					ctrl_y[rq.slot] = rq.cy;
					ctrl_z[rq.slot] = rq.cz;
				end
			end
			bsde_pkg::KIND_KNOT: begin
				if (rq.slot < bsde_pkg::KnotDepth)
					knots[rq.slot] = rq.tv;
			end
			bsde_pkg::KIND_EVAL:
				curve_points_due.insert(curve_points_due.size(), curve_at(rq.tv));
			default: ;
		endcase
	endtask

	// driver: hold the payload while stalled, otherwise maybe present the next request
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				apply_request(cur_req);
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_req = pending_reqs.pop_front();
					kind <= cur_req.kind;
					slot <= cur_req.slot;
					coord_x <= cur_req.cx;
					coord_y <= cur_req.cy;
					coord_z <= cur_req.cz;
					time_value <= cur_req.tv;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// monitor: compare each delivered point with the oldest one due, then pick a stall
	always @(posedge clk) begin
		point_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (curve_points_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected point, expected none, got %0d %0d %0d",
						$time, pos_x, pos_y, pos_z);
				end else begin
					due = curve_points_due.pop_front();
					check_field("pos_x", due.x, pos_x);
					check_field("pos_y", due.y, pos_y);
					check_field("pos_z", due.z, pos_z);
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	function automatic request_t mk_req(logic [1:0] k, logic [6:0] s, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] t);
		request_t rq;
		rq.kind = k;
		rq.slot = s;
		rq.cx = x;
		rq.cy = y;
		rq.cz = z;
		rq.tv = t;
		return rq;
	endfunction

	// coordinate: mostly moderate values, sometimes the full 32-bit range
	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
	endfunction

	// evaluation time: mostly around the loaded knot span, including both clamp sides
	function automatic logic signed [31:0] rand_time();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $signed($urandom_range(0, 280 << 16)) - (140 << 16);
	endfunction

	// nondecreasing knot vector, repeated knots now and then (zero-width spans)
	task automatic queue_knot_load();
		logic signed [31:0] kv;
		kv = -(36 << 16) - $signed($urandom_range(0, 1 << 16));
		for (int j = 0; j < bsde_pkg::KnotDepth; j++) begin
			queue_req(mk_req(bsde_pkg::KIND_KNOT, j[6:0], rand_coord(), rand_coord(),
				rand_coord(), kv));
			if ($urandom_range(0, 4) != 0)
				kv = kv + $signed($urandom_range(1, 3 << 16));
		end
	endtask

	task automatic queue_random(int count);
		int sel;
		logic [6:0] s;
		for (int j = 0; j < count; j++) begin
			sel = $urandom_range(0, 99);
			s = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(64, 127))
				: 7'($urandom_range(0, 63));
			if (sel < 30)
				queue_req(mk_req(bsde_pkg::KIND_POINT, s, rand_coord(), rand_coord(),
					rand_coord(), $urandom));
			else if (sel < 40)
				// stray knot rewrite: may break ordering, the block must still match
				queue_req(mk_req(bsde_pkg::KIND_KNOT, 7'($urandom_range(0, 127)),
					$urandom, $urandom, $urandom, rand_time()));
			else if (sel < 95)
				queue_req(mk_req(bsde_pkg::KIND_EVAL, 7'($urandom), $urandom, $urandom,
					$urandom, rand_time()));
			else
				queue_req(mk_req(KIND_NOP, 7'($urandom), $urandom, $urandom,
					$urandom, $urandom));
		end
	endtask

	// wait until every queued request is in and every point has come back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || curve_points_due.size() != 0);
	endtask

	// one register write; the valid drops before the next write may start
	task automatic write_reg(logic idx, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == bsde_pkg::CFG_ORDER)
			spline_order = data[2:0];
		else
			spline_count = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// register settings per phase: order, point count (above 64 saturates)
	int phase_order [10] = '{3, 1, 0, 7, 2, 7, 5, 7, 4, 1};
	int phase_count [10] = '{0, 1, 5, 64, 20, 127, 10, 3, 64, 100};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: evaluations with no points, ignored kinds and slots, extremes
		queue_req(mk_req(bsde_pkg::KIND_EVAL, 7'd0, '0, '0, '0, 32'sh8000_0000));
		queue_req(mk_req(bsde_pkg::KIND_EVAL, 7'd127, '0, '0, '0, 32'sh7fff_ffff));
		queue_req(mk_req(KIND_NOP, 7'd127, '1, '1, '1, '1));
		queue_req(mk_req(bsde_pkg::KIND_POINT, 7'd64, '1, '1, '1, '1));
		queue_req(mk_req(bsde_pkg::KIND_POINT, 7'd127, '1, '1, '1, '1));
		queue_req(mk_req(bsde_pkg::KIND_KNOT, 7'd72, '0, '0, '0, 32'sh7fff_ffff));
		queue_req(mk_req(bsde_pkg::KIND_KNOT, 7'd127, '0, '0, '0, 32'sh8000_0000));
		// full load so that no store entry is ever read unwritten
		for (int j = 0; j < bsde_pkg::MaxPoints; j++)
			queue_req(mk_req(bsde_pkg::KIND_POINT, j[6:0], rand_coord(), rand_coord(),
				rand_coord(), $urandom));
		queue_req(mk_req(bsde_pkg::KIND_POINT, 7'd0, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, '0));
		queue_req(mk_req(bsde_pkg::KIND_POINT, 7'd1, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, '0));
		queue_knot_load();
		queue_req(mk_req(bsde_pkg::KIND_EVAL, 7'd0, '0, '0, '0, '0));

		for (int ph = 0; ph < 10; ph++) begin
			// idle modes rotate: none, sender idle, receiver stalling, both
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 76; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 76; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			// sender holds off here until every point due has come back
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_reg(bsde_pkg::CFG_ORDER, {4'($urandom), 3'(phase_order[ph])});
			write_reg(bsde_pkg::CFG_COUNT, 7'(phase_count[ph]));
			if (ph % 3 == 0)
				queue_knot_load();
			// clamp extremes at every setting
			queue_req(mk_req(bsde_pkg::KIND_EVAL, 7'd0, '0, '0, '0, 32'sh8000_0000));
			queue_req(mk_req(bsde_pkg::KIND_EVAL, 7'd0, '0, '0, '0, 32'sh7fff_ffff));
			queue_random(RAND_PER_PHASE);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("bspline_deboor_evaluator regression: pass");
		else
			$display("bspline_deboor_evaluator regression: fail");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#200_000_000;
		$display("bspline_deboor_evaluator regression: fail");
		$finish;
	end
endmodule

/* filelist.f */
rtl/bsde_pkg.sv
rtl/bsde_datapath.sv
rtl/bsde_ctrl.sv
rtl/bspline_deboor_evaluator.sv
verif/bspline_deboor_evaluator_test.sv
